// ===== sv/array_insert_erase_engine_assert.svh =====
// assertion macros shared by the array insert/erase engine modules
// no dependencies; included inside module bodies
`ifndef ARRAY_INSERT_ERASE_ENGINE_ASSERT_SVH
`define ARRAY_INSERT_ERASE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define AIE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define AIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aie_pkg.sv =====
// shared types and constants for the array insert/erase engine
// no dependencies; imported by aie_ctrl, aie_datapath and the top level
package aie_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 7;
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 32;
  localparam int ELEM_CNT_W = 7;
  localparam int CAP_OUT_W  = 8;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY  = 3'd0,
    CMD_GET    = 3'd1,
    CMD_SET    = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_INSERT = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    close_run;
    logic    write_item;
    logic    shift_init;
    logic    shift_run;
    logic    commit_insert;
    logic    commit_erase;
    logic    ins_fail;
    logic    read_hit;
    logic    done;
    status_t status;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             idx_ok;
    logic             erase_ok;
    logic             ins_bad;
    logic             full;
    logic             shift_idle;
  } stat_t;

endpackage

// ===== sv/array_insert_erase_engine.sv =====
// query, set and rejected commands answer from decode, get waits in a read state;
// insert and erase go through the shift state, which moves up to DEPTH words
// throughput: one transaction at a time; shifts move one word per cycle through the
// one-read one-write element memory; busy drops in the cycle the result strobes
// reset: synchronous active-low rst_n empties the array, capacity 1, no insert run open;
// element memory is not cleared. results cannot be stalled by the receiver
module array_insert_erase_engine #(
  parameter int DEPTH      = aie_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aie_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [aie_pkg::CMD_W-1:0]      in_command,
  input  logic        [aie_pkg::IDX_W-1:0]      in_index,
  input  logic        [aie_pkg::CNT_W-1:0]      in_count,
  input  logic signed [aie_pkg::VAL_W-1:0]      in_value,
  input  logic                                  in_last_element,
  output logic                                  out_valid,
  output logic signed [aie_pkg::VAL_W-1:0]      out_read_value,
  output logic        [aie_pkg::ELEM_CNT_W-1:0] out_element_count,
  output logic        [aie_pkg::CAP_OUT_W-1:0]  out_capacity_value,
  output logic        [aie_pkg::STATUS_W-1:0]   out_status
);
  import aie_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  aie_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  aie_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_command         (in_command),
    .in_index           (in_index),
    .in_count           (in_count),
    .in_value           (in_value),
    .in_last_element    (in_last_element),
    .out_valid          (out_valid),
    .out_read_value     (out_read_value),
    .out_element_count  (out_element_count),
    .out_capacity_value (out_capacity_value),
    .out_status         (out_status)
  );

endmodule

// ===== sv/aie_ctrl.sv =====
// command sequencer for the array insert/erase engine
// depends on aie_pkg and array_insert_erase_engine_assert.svh
module aie_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  aie_pkg::stat_t stat,
  output aie_pkg::ctrl_t ctrl
);
  import aie_pkg::*;

  `include "array_insert_erase_engine_assert.svh"

  typedef enum logic [1:0] {
    IDLE,
    DECODE,
    SHIFT,
    GET_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.status = ST_OK;
    case (state_r)
      IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = DECODE;
        end
      end
      DECODE: begin
        state_nxt = IDLE;
        case (stat.cmd)
          CMD_QUERY: begin
            ctrl.close_run = 1'b1;
            ctrl.done      = 1'b1;
          end
          CMD_GET: begin
            ctrl.close_run = 1'b1;
            if (stat.idx_ok) begin
              state_nxt = GET_WAIT;
            end else begin
              ctrl.done   = 1'b1;
              ctrl.status = ST_INVALID;
            end
          end
          CMD_SET: begin
            ctrl.close_run = 1'b1;
            ctrl.done      = 1'b1;
            if (stat.idx_ok) begin
              ctrl.write_item = 1'b1;
            end else begin
              ctrl.status = ST_INVALID;
            end
          end
          CMD_ERASE: begin
            ctrl.close_run = 1'b1;
            if (stat.erase_ok) begin
              ctrl.shift_init = 1'b1;
              state_nxt       = SHIFT;
            end else begin
              ctrl.done   = 1'b1;
              ctrl.status = ST_INVALID;
            end
          end
          CMD_INSERT: begin
            if (stat.ins_bad) begin
              ctrl.ins_fail = 1'b1;
              ctrl.done     = 1'b1;
              ctrl.status   = ST_INVALID;
            end else if (stat.full) begin
              ctrl.ins_fail = 1'b1;
              ctrl.done     = 1'b1;
              ctrl.status   = ST_FULL;
            end else begin
              ctrl.shift_init = 1'b1;
              state_nxt       = SHIFT;
            end
          end
          default: begin
            // unknown code leaves any open run alone
            ctrl.done   = 1'b1;
            ctrl.status = ST_INVALID;
          end
        endcase
      end
      SHIFT: begin
        ctrl.shift_run = 1'b1;
        // all moves issued and the last write drained
        if (stat.shift_idle) begin
          ctrl.done = 1'b1;
          state_nxt = IDLE;
          if (stat.cmd == CMD_INSERT) begin
            ctrl.write_item    = 1'b1;
            ctrl.commit_insert = 1'b1;
          end else begin
            ctrl.commit_erase = 1'b1;
          end
        end
      end
      GET_WAIT: begin
        ctrl.read_hit = 1'b1;
        ctrl.done     = 1'b1;
        state_nxt     = IDLE;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != IDLE);
    end
  end

  assign busy = busy_r;

  `AIE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy_r, busy_r, "accept did not raise busy")
  `AIE_ASSERT_NEXT(a_done_frees, clk, rst_n, ctrl.done, !busy_r, "busy held after result")
  `AIE_ASSERT_NEXT(a_init_shift, clk, rst_n, ctrl.shift_init, ctrl.shift_run, "shift did not follow init")

endmodule

// ===== sv/aie_datapath.sv =====
// element memory, size/capacity registers, shift engine and result registers
// depends on aie_pkg and array_insert_erase_engine_assert.svh
module aie_datapath #(
  parameter int DEPTH      = aie_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = aie_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aie_pkg::ctrl_t                       ctrl,
  output aie_pkg::stat_t                       stat,
  input  logic        [aie_pkg::CMD_W-1:0]     in_command,
  input  logic        [aie_pkg::IDX_W-1:0]     in_index,
  input  logic        [aie_pkg::CNT_W-1:0]     in_count,
  input  logic signed [aie_pkg::VAL_W-1:0]     in_value,
  input  logic                                 in_last_element,
  output logic                                 out_valid,
  output logic signed [aie_pkg::VAL_W-1:0]     out_read_value,
  output logic        [aie_pkg::ELEM_CNT_W-1:0] out_element_count,
  output logic        [aie_pkg::CAP_OUT_W-1:0] out_capacity_value,
  output logic        [aie_pkg::STATUS_W-1:0]  out_status
);
  import aie_pkg::*;

  `include "array_insert_erase_engine_assert.svh"

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = $clog2(DEPTH) + 2;
  localparam int EW   = CW + IDX_W + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // latched transaction
  logic [CMD_W-1:0]      cmd_r;
  logic [IDX_W-1:0]      idx_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  last_r;

  logic [CW-1:0]   count_r;
  logic [CAPW-1:0] cap_r;
  logic [CW-1:0]   cursor_r;
  logic            run_r;

  // shift engine
  logic [CW-1:0]         moves_r;
  logic [CW-1:0]         pos_r;
  logic [AW-1:0]         rptr_r;
  logic [AW-1:0]         wptr_r;
  logic                  pend_r;
  logic [AW-1:0]         pend_addr_r;
  logic [DATA_WIDTH-1:0] rdata_r;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_read_r;
  status_t               out_status_r;

  logic [EW-1:0]               idx_e, cnt_e, count_e;
  logic [CW-1:0]               pos_sel;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               item_addr;
  logic                        is_insert;
  logic [VAL_W+DATA_WIDTH-1:0] val_ext;
  logic [VAL_W+DATA_WIDTH-1:0] rd_ext;

  assign idx_e     = EW'(idx_r);
  assign cnt_e     = EW'(cnt_r);
  assign count_e   = EW'(count_r);
  assign is_insert = (cmd_r == CMD_INSERT);
  assign pos_sel   = run_r ? cursor_r : CW'(idx_r);
  assign raddr     = ctrl.shift_run ? rptr_r : AW'(idx_r);
  assign item_addr = is_insert ? AW'(pos_r) : AW'(idx_r);

  // value sign-extended or cut to the stored word width
  assign val_ext = {{DATA_WIDTH{in_value[VAL_W-1]}}, in_value};
  // stored word zero-extended or cut to the port width
  assign rd_ext  = {{VAL_W{1'b0}}, rdata_r};

  always_comb begin
    stat.cmd        = cmd_r;
    stat.idx_ok     = (idx_e < count_e);
    stat.erase_ok   = ((idx_e + cnt_e) <= count_e);
    stat.ins_bad    = !run_r && (idx_e > count_e);
    stat.full       = (count_r == CW'(DEPTH));
    stat.shift_idle = (moves_r == '0) && !pend_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_command;
      idx_r  <= in_index;
      cnt_r  <= in_count;
      val_r  <= val_ext[DATA_WIDTH-1:0];
      last_r <= in_last_element;
    end
  end

  // element memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (pend_r) begin
      mem[pend_addr_r] <= rdata_r;
    end else if (ctrl.write_item) begin
      mem[item_addr] <= val_r;
    end
  end

  // shift addresses, no reset needed
  always_ff @(posedge clk) begin
    pend_addr_r <= wptr_r;
    if (ctrl.shift_init) begin
      if (is_insert) begin
        pos_r  <= pos_sel;
        rptr_r <= AW'(count_r - CW'(1));
        wptr_r <= AW'(count_r);
      end else begin
        rptr_r <= AW'(idx_e + cnt_e);
        wptr_r <= AW'(idx_e);
      end
    end else if (ctrl.shift_run && (moves_r != '0)) begin
      // insert walks down from the top, erase walks up from the gap
      if (is_insert) begin
        rptr_r <= rptr_r - AW'(1);
        wptr_r <= wptr_r - AW'(1);
      end else begin
        rptr_r <= rptr_r + AW'(1);
        wptr_r <= wptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAPW'(1);
      cursor_r    <= '0;
      run_r       <= 1'b0;
      moves_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.done;
      pend_r      <= ctrl.shift_run && (moves_r != '0);

      if (ctrl.shift_init) begin
        if (is_insert) begin
          moves_r <= count_r - pos_sel;
        end else begin
          moves_r <= CW'(count_e - idx_e - cnt_e);
        end
      end else if (ctrl.shift_run && (moves_r != '0)) begin
        moves_r <= moves_r - CW'(1);
      end

      if (ctrl.close_run) begin
        run_r <= 1'b0;
      end else if (ctrl.commit_insert) begin
        run_r <= !last_r;
      end else if (ctrl.ins_fail && last_r) begin
        run_r <= 1'b0;
      end

      if (ctrl.commit_insert) begin
        count_r  <= count_r + CW'(1);
        cursor_r <= pos_r + CW'(1);
        if ((CAPW'(count_r) + CAPW'(1)) >= cap_r) begin
          cap_r <= cap_r << 1;
        end
      end else if (ctrl.commit_erase) begin
        count_r <= count_r - CW'(cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_status_r <= ctrl.status;
      out_read_r   <= ctrl.read_hit ? rd_ext[VAL_W-1:0] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_read_r;
  assign out_status         = out_status_r;
  assign out_element_count  = ELEM_CNT_W'(count_r);
  assign out_capacity_value = CAP_OUT_W'(cap_r);

  `AIE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "size above depth")
  `AIE_ASSERT_IMPL(a_cap_pow2, clk, rst_n, 1'b1, $onehot(cap_r), "capacity not a power of two")
  `AIE_ASSERT_IMPL(a_cap_above, clk, rst_n, 1'b1, CAPW'(count_r) < cap_r, "capacity not above size")
  `AIE_ASSERT_IMPL(a_wr_port, clk, rst_n, pend_r, !ctrl.write_item, "write port conflict")

endmodule

// ===== tb/array_insert_erase_engine_test.sv =====
// self-checking testbench for array_insert_erase_engine: directed table, then random command mix
// depends on aie_pkg and the array_insert_erase_engine rtl; checks typed rows, else a shadow array
`timescale 1ns / 1ps

module array_insert_erase_engine_test;
  import aie_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int ARRAY_DEPTH = DEPTH_DEF;
  localparam int ITEM_TARGET = 1650;
  localparam int DRAIN_EVERY = 300;

  // command codes the block answers as invalid
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        index;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
    logic                    last_element;
  } array_cmd_t;

  typedef struct {
    logic signed [VAL_W-1:0]  read_value;
    logic [ELEM_CNT_W-1:0]    element_count;
    logic [CAP_OUT_W-1:0]     capacity_value;
    logic [STATUS_W-1:0]      status;
  } array_resp_t;

  typedef struct {
    array_cmd_t  cmd;
    bit          typed;
    array_resp_t resp;
  } array_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [CMD_W-1:0]            in_command;
  logic [IDX_W-1:0]            in_index;
  logic [CNT_W-1:0]            in_count;
  logic signed [VAL_W-1:0]     in_value;
  logic                        in_last_element;
  logic                        out_valid;
  logic signed [VAL_W-1:0]     out_read_value;
  logic [ELEM_CNT_W-1:0]       out_element_count;
  logic [CAP_OUT_W-1:0]        out_capacity_value;
  logic [STATUS_W-1:0]         out_status;

  // shadow copy of the block state
  logic signed [VAL_W-1:0] shadow_words [ARRAY_DEPTH];
  int unsigned             shadow_size;
  int unsigned             shadow_capacity;
  int unsigned             shadow_cursor;
  bit                      shadow_run_open;

  array_resp_t pending_results [$];
  array_row_t  directed_rows [$];
  array_resp_t blank_resp;
  int          fail_count;
  int          items_sent;
  int          burst_left;

  array_insert_erase_engine DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_index           (in_index),
    .in_count           (in_count),
    .in_value           (in_value),
    .in_last_element    (in_last_element),
    .out_valid          (out_valid),
    .out_read_value     (out_read_value),
    .out_element_count  (out_element_count),
    .out_capacity_value (out_capacity_value),
    .out_status         (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [STATUS_W-1:0] place_word(int unsigned pos, logic signed [VAL_W-1:0] word);
    int unsigned k;
    if (shadow_size >= ARRAY_DEPTH) return ST_FULL;
    for (k = shadow_size; k > pos; k--) shadow_words[k] = shadow_words[k - 1];
    shadow_words[pos] = word;
    shadow_size++;
    while (shadow_size >= shadow_capacity) shadow_capacity *= 2;
    return ST_OK;
  endfunction

  function automatic array_resp_t apply_to_shadow_array(array_cmd_t c);
    array_resp_t r;
    int unsigned idx;
    int unsigned cnt;
    int unsigned k;
    r.read_value = '0;
    r.status = ST_OK;
    idx = c.index;
    cnt = c.count;
    if (c.command <= CMD_ERASE) shadow_run_open = 1'b0;
    case (c.command)
      CMD_QUERY: ;
      CMD_GET: begin
        if (idx < shadow_size) r.read_value = shadow_words[idx];
        else r.status = ST_INVALID;
      end
      CMD_SET: begin
        if (idx < shadow_size) shadow_words[idx] = c.value;
        else r.status = ST_INVALID;
      end
      CMD_ERASE: begin
        if (idx + cnt <= shadow_size) begin
          for (k = idx; k + cnt < shadow_size; k++) shadow_words[k] = shadow_words[k + cnt];
          shadow_size -= cnt;
        end else begin
          r.status = ST_INVALID;
        end
      end
      CMD_INSERT: begin
        if (!shadow_run_open) begin
          // range check on the first element wins over the full check
          if (idx > shadow_size) begin
            r.status = ST_INVALID;
          end else begin
            r.status = place_word(idx, c.value);
            if (r.status == ST_OK) begin
              shadow_cursor = idx + 1;
              shadow_run_open = 1'b1;
            end
          end
        end else begin
          r.status = place_word(shadow_cursor, c.value);
          if (r.status == ST_OK) shadow_cursor++;
        end
        if (c.last_element) shadow_run_open = 1'b0;
      end
      default: r.status = ST_INVALID;
    endcase
    r.element_count = ELEM_CNT_W'(shadow_size);
    r.capacity_value = CAP_OUT_W'(shadow_capacity);
    return r;
  endfunction

  function automatic array_cmd_t make_cmd(logic [CMD_W-1:0] command, int unsigned idx,
                                          int unsigned cnt, logic signed [VAL_W-1:0] value,
                                          bit last);
    array_cmd_t c;
    c.command = command;
    c.index = IDX_W'(idx);
    c.count = CNT_W'(cnt);
    c.value = value;
    c.last_element = last;
    return c;
  endfunction

  function automatic array_row_t make_row(array_cmd_t c, bit typed,
                                          logic signed [VAL_W-1:0] rd, int unsigned size,
                                          int unsigned cap, logic [STATUS_W-1:0] st);
    array_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.resp.read_value = rd;
    row.resp.element_count = ELEM_CNT_W'(size);
    row.resp.capacity_value = CAP_OUT_W'(cap);
    row.resp.status = st;
    return row;
  endfunction

  // one transaction on the command port, then a random idle gap unless a burst runs or starts
  task automatic issue(array_cmd_t c, bit typed, array_resp_t typed_resp);
    array_resp_t predicted;
    @(negedge clk);
    start <= 1'b1;
    in_command <= c.command;
    in_index <= c.index;
    in_count <= c.count;
    in_value <= c.value;
    in_last_element <= c.last_element;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_to_shadow_array(c);
    pending_results.push_back(typed ? typed_resp : predicted);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
    end else begin
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(logic [CMD_W-1:0] command, int unsigned idx, int unsigned cnt, bit last);
    issue(make_cmd(command, idx, cnt, $urandom, last), 1'b0, blank_resp);
  endtask

  task automatic insert_run(int unsigned first_idx, int unsigned len, bit closed);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      send_random(CMD_INSERT, (k == 0) ? first_idx : $urandom_range(0, shadow_size),
                  $urandom_range(0, 127),
                  (k == len - 1 && closed) || $urandom_range(0, 29) == 0);
    end
  endtask

  task automatic random_episode();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    // keep occupancy moving: near the top, favor erase over insert
    if (shadow_size > 56 && pick < 40 && $urandom_range(0, 1) == 0) pick = 60;
    if (pick < 40) begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, shadow_size);
      insert_run(idx, $urandom_range(1, 10), $urandom_range(0, 4) != 0);
    end else if (pick < 60) begin
      if (shadow_size > 0 && $urandom_range(0, 7) != 0) idx = $urandom_range(0, shadow_size - 1);
      else idx = $urandom_range(0, 127);
      send_random($urandom_range(0, 1) ? CMD_GET : CMD_SET, idx, $urandom_range(0, 127),
                  1'($urandom_range(0, 1)));
    end else if (pick < 75) begin
      if ($urandom_range(0, 7) == 0) begin
        send_random(CMD_ERASE, $urandom_range(0, 127), $urandom_range(0, 127),
                    1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 5) == 0) begin
        send_random(CMD_ERASE, 0, shadow_size, 1'($urandom_range(0, 1)));
      end else begin
        idx = $urandom_range(0, shadow_size);
        send_random(CMD_ERASE, idx, $urandom_range(0, shadow_size - idx),
                    1'($urandom_range(0, 1)));
      end
    end else if (pick < 80) begin
      send_random(CMD_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                  1'($urandom_range(0, 1)));
    end else if (pick < 83) begin
      // run past the top of the store so the full case and its closing element show up
      insert_run($urandom_range(0, shadow_size), ARRAY_DEPTH - shadow_size + $urandom_range(1, 3),
                 1'b1);
    end else begin
      send_random(CMD_W'($urandom_range(CMD_QUERY, CMD_RSVD7)), $urandom_range(0, 127),
                  $urandom_range(0, 127), 1'($urandom_range(0, 1)));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    array_resp_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result strobed with no transaction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_element_count !== want.element_count) begin
          $error("element_count: expected %0d, actual %0d", want.element_count, out_element_count);
          fail_count++;
        end
        if (out_capacity_value !== want.capacity_value) begin
          $error("capacity_value: expected %0d, actual %0d", want.capacity_value,
                 out_capacity_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int next_drain;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_QUERY;
    in_index = '0;
    in_count = '0;
    in_value = '0;
    in_last_element = 1'b0;
    blank_resp = '{default: '0};
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    shadow_size = 0;
    shadow_capacity = 1;
    shadow_cursor = 0;
    shadow_run_open = 1'b0;

    // empty store
    directed_rows.push_back(make_row(make_cmd(CMD_QUERY, 0, 0, 0, 0), 1, 0, 0, 1, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_GET, 0, 0, 0, 0), 1, 0, 0, 1, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_SET, 0, 0, 1, 0), 1, 0, 0, 1, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_ERASE, 0, 0, 0, 0), 1, 0, 0, 1, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_ERASE, 0, 1, 0, 0), 1, 0, 0, 1, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 1, 0, 3, 1), 1, 0, 0, 1, ST_INVALID));
    // three-element run with the value extremes
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 0, 0, 32'sh7fff_ffff, 0), 1, 0, 1, 2,
                                     ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 0, 0, 32'sh8000_0000, 0), 1, 0, 2, 4,
                                     ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 127, 127, -1, 1), 1, 0, 3, 4, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_GET, 0, 0, 0, 0), 1, 32'sh7fff_ffff, 3, 4,
                                     ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_GET, 2, 0, 0, 0), 1, -1, 3, 4, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_GET, 3, 0, 0, 0), 1, 0, 3, 4, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_SET, 1, 0, 0, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 64, 0, 7, 1), 1, 0, 3, 4, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_RSVD5, 0, 0, 0, 0), 1, 0, 3, 4, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_RSVD7, 127, 127, -1, 1), 1, 0, 3, 4,
                                     ST_INVALID));
    // unknown command inside an open run leaves the run open
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 1, 0, 5, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_RSVD6, 0, 0, 0, 0), 1, 0, 4, 8, ST_INVALID));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 0, 0, 6, 0), 0, 0, 0, 0, ST_OK));
    // get closes the run, so the next insert starts over at its own index
    directed_rows.push_back(make_row(make_cmd(CMD_GET, 1, 0, 0, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_INSERT, 0, 0, 9, 1), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_ERASE, 1, 2, 0, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_ERASE, 0, 127, 0, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_ERASE, 127, 0, 0, 0), 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(make_row(make_cmd(CMD_SET, 0, 0, 32'sh8000_0000, 0), 0, 0, 0, 0,
                                     ST_OK));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].resp);
    drain_pending();

    next_drain = items_sent + DRAIN_EVERY;
    while (items_sent < ITEM_TARGET) begin
      random_episode();
      if (items_sent >= next_drain) begin
        drain_pending();
        next_drain += DRAIN_EVERY;
      end
    end

    drain_pending();
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== array_insert_erase_engine.f =====
+incdir+sv
sv/aie_pkg.sv
sv/aie_ctrl.sv
sv/aie_datapath.sv
sv/array_insert_erase_engine.sv
tb/array_insert_erase_engine_test.sv
